/* design/apm_pkg.sv */
package apm_pkg;

  // Width of a column entry inside the array: holds values up to 64 plus one
  localparam int unsigned DistW = 7;
  // Width of the reported distance and of the length and limit registers
  localparam int unsigned RegW = 6;
  // Pattern bytes held in configuration words
  localparam int unsigned WordBytes = 8;
  localparam int unsigned NumWords = 4;
  localparam int unsigned CfgBytes = WordBytes * NumWords;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  typedef logic [DistW-1:0] dist_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLength = 3'd0,
    CfgErrorLimit    = 3'd1,
    CfgPatternWord0  = 3'd2,
    CfgPatternWord1  = 3'd3,
    CfgPatternWord2  = 3'd4,
    CfgPatternWord3  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_start;
  } in_t;

  typedef struct packed {
    logic            match;
    logic [RegW-1:0] distance;
  } out_t;

  // What travels from one cell to the next with each text byte
  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_start;
    dist_t      left;
    dist_t      result;
    logic       match;
  } token_t;

  // Settings shared by every cell
  typedef struct packed {
    dist_t           cap;
    logic [RegW-1:0] error_limit;
    dist_t           eff_len;
  } cell_cfg_t;

  function automatic dist_t dist_min(dist_t a, dist_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

/* design/apm_cell.sv */
module apm_cell #(
  parameter int unsigned Pos = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               up_valid_i,
  input  apm_pkg::token_t    up_tok_i,
  output logic               up_ready_o,
  output logic               valid_o,
  output apm_pkg::token_t    tok_o,
  input  logic               ready_i,
  input  logic [7:0]         pat_byte_i,
  input  apm_pkg::cell_cfg_t cfg_i
);
  import apm_pkg::*;

  localparam dist_t PosD      = DistW'(Pos);
  localparam dist_t PosPrevD  = DistW'(Pos - 1);
  localparam dist_t ResetSelf = dist_t'(1);
  localparam dist_t ResetDiag = (Pos == 1) ? dist_t'(0) : dist_t'(1);

  logic   valid_q;
  token_t tok_q, tok_d;
  dist_t  self_q, diag_q;
  dist_t  new_val;
  logic   take;

  // Cell is free when empty or when its token moves on this cycle
  assign up_ready_o = !valid_q || ready_i;
  assign take       = up_valid_i && up_ready_o;

  // Update this entry of the column for the incoming byte
  always_comb begin
    dist_t old_self;
    dist_t old_diag;
    dist_t cost;
    old_self = up_tok_i.line_start ? dist_min(PosD, cfg_i.cap) : self_q;
    old_diag = up_tok_i.line_start ? dist_min(PosPrevD, cfg_i.cap) : diag_q;
    cost     = old_diag + ((up_tok_i.text_byte != pat_byte_i) ? dist_t'(1) : dist_t'(0));
    new_val  = dist_min(dist_min(cost, up_tok_i.left + dist_t'(1)),
                        dist_min(old_self + dist_t'(1), cfg_i.cap));

    tok_d      = up_tok_i;
    tok_d.left = new_val;
    // Capture the result at the pattern end
    if (PosD == cfg_i.eff_len) begin
      tok_d.result = new_val;
      tok_d.match  = (new_val <= {1'b0, cfg_i.error_limit});
    end
  end

  // Hold valid unless the token leaves or a new one arrives
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      self_q  <= ResetSelf;
      diag_q  <= ResetDiag;
    end else begin
      if (up_ready_o) begin
        valid_q <= up_valid_i;
      end
      if (take) begin
        self_q <= new_val;
        diag_q <= up_tok_i.left;
      end
    end
  end

  // Advance the payload with the transfer
  always_ff @(posedge clk_i) begin
    if (take) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

/* design/approximate_pattern_match.sv */
// Approximate pattern matcher: edit-distance search of a text stream against
// one configured pattern of up to MAX_PATTERN bytes.
// Configuration: write pattern_length (0), error_limit (1) and the four
// pattern words (2..5) through cfg_*; cfg_ready_o is always high. Write
// only while no text byte is in flight.
// Input: one text byte per transfer on in_valid_i / in_stall_o; line_start
// reloads the initial column before the byte is used.
// Output: one result per byte on out_valid_o / out_stall_i, in order, giving
// the distance at the pattern end (saturated at limit plus one) and a match
// flag.
// Throughput is one byte per cycle while the receiver does not stall. Each
// byte walks a chain of MAX_PATTERN cells, one column entry per cell, and
// its result is shown from the last cell (the last cell is the output register).
// When the receiver stalls, the held result stays put while bytes behind it
// close up any gaps; in_stall_o rises once the chain is full.
// Reset empties the chain, sets length 1, limit 0, clears the pattern and
// loads the initial column.
module approximate_pattern_match #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [apm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [apm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  apm_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output apm_pkg::out_t                 out_data_o
);
  import apm_pkg::*;

  logic [RegW-1:0]     pattern_length_q;
  logic [RegW-1:0]     error_limit_q;
  logic [CfgDataW-1:0] pattern_word_q [NumWords];

  cell_cfg_t cell_cfg;
  logic [7:0] pat_byte [MAX_PATTERN];

  logic   chain_valid [MAX_PATTERN+1];
  logic   chain_ready [MAX_PATTERN+1];
  token_t chain_tok   [MAX_PATTERN+1];

  // Take configuration writes at once
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= RegW'(1);
      error_limit_q    <= '0;
      for (int i = 0; i < NumWords; i++) begin
        pattern_word_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPatternLength: pattern_length_q  <= cfg_data_i[RegW-1:0];
        CfgErrorLimit:    error_limit_q     <= cfg_data_i[RegW-1:0];
        CfgPatternWord0:  pattern_word_q[0] <= cfg_data_i;
        CfgPatternWord1:  pattern_word_q[1] <= cfg_data_i;
        CfgPatternWord2:  pattern_word_q[2] <= cfg_data_i;
        CfgPatternWord3:  pattern_word_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the pattern length and form the saturation cap
  always_comb begin
    cell_cfg.cap         = {1'b0, error_limit_q} + dist_t'(1);
    cell_cfg.error_limit = error_limit_q;
    if (pattern_length_q == '0) begin
      cell_cfg.eff_len = dist_t'(1);
    end else if ({1'b0, pattern_length_q} > DistW'(MAX_PATTERN)) begin
      cell_cfg.eff_len = DistW'(MAX_PATTERN);
    end else begin
      cell_cfg.eff_len = {1'b0, pattern_length_q};
    end
  end

  // Spread the pattern bytes over the cells; bytes past the words are zero
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    if (k < CfgBytes) begin : g_cfg
      assign pat_byte[k] = pattern_word_q[k / WordBytes][(k % WordBytes) * 8 +: 8];
    end else begin : g_zero
      assign pat_byte[k] = 8'h00;
    end
  end

  // Entry zero of the column is always zero, so the first cell sees left 0
  always_comb begin
    chain_tok[0]            = '0;
    chain_tok[0].text_byte  = in_data_i.text_byte;
    chain_tok[0].line_start = in_data_i.line_start;
  end
  assign chain_valid[0] = in_valid_i;
  assign in_stall_o     = !chain_ready[0];

  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    apm_cell #(
      .Pos(j)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (chain_valid[j-1]),
      .up_tok_i   (chain_tok[j-1]),
      .up_ready_o (chain_ready[j-1]),
      .valid_o    (chain_valid[j]),
      .tok_o      (chain_tok[j]),
      .ready_i    (chain_ready[j]),
      .pat_byte_i (pat_byte[j-1]),
      .cfg_i      (cell_cfg)
    );
  end

  // Last cell doubles as the output register
  assign chain_ready[MAX_PATTERN] = !out_stall_i;
  assign out_valid_o              = chain_valid[MAX_PATTERN];
  assign out_data_o.match         = chain_tok[MAX_PATTERN].match;
  assign out_data_o.distance      = chain_tok[MAX_PATTERN].result[RegW-1:0];

endmodule

/* design/apm_checker.sv */
module apm_checker #(
  parameter int unsigned MaxPattern = 32
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input apm_pkg::out_t out_data_o
);
  import apm_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or vanished");

  // A free output end leaves the whole chain free to take a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while output side can drain");

  // A distance never exceeds the chain length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_data_o.distance} <= DistW'(MaxPattern)))
    else $error("distance beyond pattern capacity");

  // Nothing leaves the chain straight after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result shown right after reset");

endmodule

bind approximate_pattern_match apm_checker #(
  .MaxPattern(MAX_PATTERN)
) u_apm_checker (.*);

/* dv/tb_approximate_pattern_match.sv */
module tb_approximate_pattern_match;
  import apm_pkg::*;

  localparam int unsigned MaxPattern = 32;
  localparam int unsigned RandomItems = 1700;
  // Indexes past the register list: writes to these must be ignored
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;

  // Shadow copy of the registers and of the distance column
  logic [RegW-1:0]     len_q;
  logic [RegW-1:0]     limit_q;
  logic [CfgDataW-1:0] words_q [NumWords];
  int unsigned         dist_col [0:MaxPattern];

  in_t         text_backlog [$];
  out_t        expected_scores [$];
  out_t        want;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned mismatches = 0;
  bit          steady_run = 1'b0;

  approximate_pattern_match #(
    .MAX_PATTERN(MaxPattern)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] pattern_byte(int unsigned idx);
    if ((idx >> 3) >= NumWords) return 8'h00;
    return words_q[idx >> 3][(idx & 7) * 8 +: 8];
  endfunction

  // Length zero counts as one, lengths past the array saturate
  function automatic int unsigned active_length();
    if (len_q == 0) return 1;
    if (len_q > MaxPattern) return MaxPattern;
    return 32'(len_q);
  endfunction

  function automatic int unsigned umin(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // Advance the shadow column by one text byte and return the expected score
  function automatic out_t score_text_byte(in_t item);
    int unsigned cap;
    int unsigned v;
    int unsigned j;
    int unsigned nxt [0:MaxPattern];
    out_t        score;
    cap = limit_q + 1;
    if (item.line_start) begin
      for (j = 0; j <= MaxPattern; j++) dist_col[j] = umin(j, cap);
    end
    nxt[0] = 0;
    for (j = 1; j <= MaxPattern; j++) begin
      v = dist_col[j-1] + ((pattern_byte(j - 1) == item.text_byte) ? 0 : 1);
      v = umin(v, nxt[j-1] + 1);
      v = umin(v, dist_col[j] + 1);
      nxt[j] = umin(v, cap);
    end
    for (j = 0; j <= MaxPattern; j++) dist_col[j] = nxt[j];
    v = dist_col[active_length()];
    score.match = (v <= limit_q);
    score.distance = v[RegW-1:0];
    return score;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_run) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: present queued bytes, hold the payload while stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_scores.push_back(score_text_byte(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (text_backlog.size() != 0) begin
          in_data_i <= text_backlog.pop_front();
          in_valid_i <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expected score
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_scores.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got match=%0b distance=%0d",
                   $time, out_data_o.match, out_data_o.distance);
        end else begin
          want = expected_scores.pop_front();
          if (out_data_o.match !== want.match) begin
            mismatches++;
            $display("%0t: match mismatch, expected %0b, got %0b",
                     $time, want.match, out_data_o.match);
          end
          if (out_data_o.distance !== want.distance) begin
            mismatches++;
            $display("%0t: distance mismatch, expected %0d, got %0d",
                     $time, want.distance, out_data_o.distance);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  // Write one register; leaves valid high, the caller drops it after the batch
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgPatternLength: len_q = val[RegW-1:0];
      CfgErrorLimit:    limit_q = val[RegW-1:0];
      CfgPatternWord0:  words_q[0] = val;
      CfgPatternWord1:  words_q[1] = val;
      CfgPatternWord2:  words_q[2] = val;
      CfgPatternWord3:  words_q[3] = val;
      default: ;
    endcase
  endtask

  // Program all registers; junk in the upper bits of length and limit
  task automatic program_regs(input logic [RegW-1:0] len, input logic [RegW-1:0] lim,
                              input logic [CfgDataW-1:0] w0, input logic [CfgDataW-1:0] w1,
                              input logic [CfgDataW-1:0] w2, input logic [CfgDataW-1:0] w3,
                              input bit spare);
    logic [CfgDataW-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(CfgPatternLength, {junk[CfgDataW-1:RegW], len});
    junk = {$urandom, $urandom};
    write_reg(CfgErrorLimit, {junk[CfgDataW-1:RegW], lim});
    write_reg(CfgPatternWord0, w0);
    write_reg(CfgPatternWord1, w1);
    write_reg(CfgPatternWord2, w2);
    write_reg(CfgPatternWord3, w3);
    if (spare) begin
      write_reg(CfgSpareLo, {$urandom, $urandom});
      write_reg(CfgSpareHi, {$urandom, $urandom});
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (text_backlog.size() != 0 || in_valid_i || expected_scores.size() != 0);
  endtask

  function automatic void queue_text(logic [7:0] b, logic ls);
    in_t item;
    item.text_byte = b;
    item.line_start = ls;
    text_backlog.push_back(item);
  endfunction

  function automatic logic [CfgDataW-1:0] random_word(bit narrow);
    logic [CfgDataW-1:0] w;
    int unsigned k;
    w = {$urandom, $urandom};
    if (narrow) begin
      for (k = 0; k < WordBytes; k++) w[k*8 +: 8] = 8'(8'h61 + $urandom_range(0, 3));
    end
    return w;
  endfunction

  // Fill one phase: mostly mutated copies of the pattern, some noise
  function automatic void queue_phase_text(int unsigned count, bit narrow);
    int unsigned n;
    int unsigned j;
    int unsigned r;
    logic        ls;
    logic [7:0]  noise;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 8) begin
        ls = ($urandom_range(0, 9) < 3);
        for (j = 0; j < active_length() && n < count; j++) begin
          r = $urandom_range(0, 99);
          noise = narrow ? 8'(8'h61 + $urandom_range(0, 3)) : 8'($urandom_range(0, 255));
          if (r < 5) begin
            // drop this pattern byte
          end else if (r < 10) begin
            queue_text(noise, ls);
            queue_text(pattern_byte(j), 1'b0);
            n += 2;
            ls = 1'b0;
          end else if (r < 15) begin
            queue_text(noise, ls);
            n++;
            ls = 1'b0;
          end else begin
            queue_text(pattern_byte(j), ls || ($urandom_range(0, 49) == 0));
            n++;
            ls = 1'b0;
          end
        end
      end else begin
        r = $urandom_range(1, 6);
        for (j = 0; j < r; j++) begin
          queue_text(8'($urandom_range(0, 255)), ($urandom_range(0, 19) == 0));
        end
        n += r;
      end
    end
  endfunction

  initial begin
    int unsigned     j;
    int unsigned     sent;
    int unsigned     count;
    int unsigned     r;
    bit              narrow;
    logic [RegW-1:0] len;
    logic [RegW-1:0] lim;

    // Shadow state after reset
    len_q = RegW'(1);
    limit_q = '0;
    for (j = 0; j < NumWords; j++) words_q[j] = '0;
    for (j = 0; j <= MaxPattern; j++) dist_col[j] = umin(j, 1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one-byte pattern of zero, exact match only
    queue_text(8'h00, 1'b0);
    queue_text(8'hFF, 1'b0);
    queue_text(8'h00, 1'b1);
    queue_text(8'h01, 1'b0);
    queue_text(8'h80, 1'b0);
    wait_drained();

    // Length zero behaves as one; spare indexes ignored
    program_regs(6'd0, 6'd0, {CfgDataW{1'b1}}, '0, '0, '0, 1'b1);
    queue_text(8'hFF, 1'b0);
    queue_text(8'h7F, 1'b0);
    queue_text(8'hFF, 1'b0);
    wait_drained();

    // Length past the array saturates, largest limit
    program_regs(6'd63, 6'd63, {CfgDataW{1'b1}}, {CfgDataW{1'b1}},
                 {CfgDataW{1'b1}}, {CfgDataW{1'b1}}, 1'b0);
    queue_text(8'hFF, 1'b1);
    queue_text(8'hFF, 1'b0);
    queue_text(8'h00, 1'b0);
    queue_text(8'hFF, 1'b0);
    wait_drained();

    // Full length pattern, exact match only, column reloaded at the first byte
    program_regs(6'd32, 6'd0, random_word(1'b0), random_word(1'b0),
                 random_word(1'b0), random_word(1'b0), 1'b0);
    for (j = 0; j < 6; j++) queue_text(pattern_byte(j), (j == 0));
    wait_drained();

    // Short pattern with a limit far above it
    program_regs(6'd1, 6'd32, random_word(1'b1), '0, '0, '0, 1'b0);
    queue_text(pattern_byte(0), 1'b0);
    queue_text(8'h00, 1'b1);
    queue_text(pattern_byte(0), 1'b0);
    wait_drained();

    // Random phases with fresh settings each time
    sent = 0;
    while (sent < RandomItems) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       len = '0;
        1:       len = RegW'($urandom_range(33, 63));
        2:       len = RegW'(32);
        3:       len = RegW'(1);
        default: len = RegW'($urandom_range(1, 32));
      endcase
      r = $urandom_range(0, 9);
      case (r)
        0:       lim = '0;
        1:       lim = RegW'(32);
        2:       lim = RegW'($urandom_range(33, 63));
        default: lim = RegW'($urandom_range(0, 6));
      endcase
      narrow = ($urandom_range(0, 1) == 1);
      steady_run <= ($urandom_range(0, 3) == 0);
      program_regs(len, lim, random_word(narrow), random_word(narrow),
                   random_word(narrow), random_word(narrow), ($urandom_range(0, 6) == 0));
      count = $urandom_range(20, 64);
      queue_phase_text(count, narrow);
      sent += text_backlog.size();
      wait_drained();
    end

    // Let any stray result surface before the verdict
    repeat (MaxPattern + 16) @(posedge clk_i);
    if (mismatches == 0 && expected_scores.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
design/apm_pkg.sv
design/apm_cell.sv
design/approximate_pattern_match.sv
design/apm_checker.sv
dv/tb_approximate_pattern_match.sv
